// File: rtl/cdq_pkg.sv
// Package for the circular deque: sizes, request codes and cell control type.
package cdq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned NUM_CELLS = DEPTH - 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH);
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned FILL_W    = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_e;

  typedef logic [DATA_W-1:0] data_t;

  // One-hot command broadcast to every cell; only set for a transaction that succeeds.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic clear;
  } cdq_ctl_t;

endpackage

// File: rtl/cdq_if.sv
// Request and response channel interfaces of the circular deque.
interface cdq_req_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, kind, push_value, input ready);
  modport sink   (input valid, kind, push_value, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] pop_value;
  logic                     is_empty;
  logic                     is_full;
  logic [FILL_W-1:0]        fill_count;

  modport source (output valid, ok, pop_value, is_empty, is_full, fill_count, input ready);
  modport sink   (input valid, ok, pop_value, is_empty, is_full, fill_count, output ready);
endinterface

// File: rtl/cdq_cell.sv
// One storage cell of the deque chain: holds a word and its occupied flag.
module cdq_cell import cdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cdq_ctl_t ctl_i,
  input  data_t    push_value_i,
  input  data_t    left_data_i,
  input  logic     left_valid_i,
  input  data_t    right_data_i,
  input  logic     right_valid_i,
  output data_t    data_o,
  output logic     valid_o,
  output data_t    tail_data_o
);

  data_t data_q, data_d;
  logic  valid_q, valid_d;
  logic  is_tail;

  assign is_tail = valid_q && !right_valid_i;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (ctl_i.clear) begin
      valid_d = 1'b0;
    end else if (ctl_i.push_front) begin
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (ctl_i.pop_front) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (ctl_i.push_back) begin
      // first free cell takes the new word
      if (!valid_q && left_valid_i) begin
        data_d  = push_value_i;
        valid_d = 1'b1;
      end
    end else if (ctl_i.pop_back) begin
      if (is_tail) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o      = data_q;
  assign valid_o     = valid_q;
  assign tail_data_o = is_tail ? data_q : '0;

endmodule

// File: rtl/circular_deque_unit.sv
// Top level of the circular deque: a shifting chain of storage cells.
//
//   channel   dir   fields                                         accepted when
//   req_i     in    kind, push_value                               valid && ready
//   rsp_o     out   ok, pop_value, is_empty, is_full, fill_count   valid && ready
//
// One transaction per cycle while rsp_o keeps taking responses; the response appears in the cycle after the request.
// Every cell updates in the same cycle as its neighbors, so the chain sets no extra latency.
// Request ready is held off only while a response waits and rsp_o.ready is low.
// Reset empties the chain (all occupied flags cleared) at once; no clearing pass.
module circular_deque_unit import cdq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  cdq_req_if.sink  req_i,
  cdq_rsp_if.source rsp_o
);

  cdq_ctl_t          ctl;
  logic              accept;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ok;
  data_t             popped;
  data_t             tail_or;
  logic              not_full, not_empty;

  data_t cell_data  [NUM_CELLS];
  logic  cell_valid [NUM_CELLS];
  data_t cell_tail  [NUM_CELLS];

  logic              rsp_valid_q;
  logic              rsp_ok_q;
  data_t             rsp_pop_q;
  logic              rsp_empty_q;
  logic              rsp_full_q;
  logic [FILL_W-1:0] rsp_fill_q;
  logic [CNT_W+FILL_W-1:0] fill_ext;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign not_full  = count_q != CNT_W'(NUM_CELLS);
  assign not_empty = count_q != '0;

  always_comb begin
    ctl     = '0;
    ok      = 1'b0;
    count_d = count_q;
    popped  = '0;
    case (req_i.kind)
      KIND_PUSH_FRONT: begin
        if (not_full) begin
          ctl.push_front = accept;
          ok             = 1'b1;
          count_d        = count_q + 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        if (not_full) begin
          ctl.push_back = accept;
          ok            = 1'b1;
          count_d       = count_q + 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (not_empty) begin
          ctl.pop_front = accept;
          ok            = 1'b1;
          count_d       = count_q - 1'b1;
          popped        = cell_data[0];
        end
      end
      KIND_POP_BACK: begin
        if (not_empty) begin
          ctl.pop_back = accept;
          ok           = 1'b1;
          count_d      = count_q - 1'b1;
          popped       = tail_or;
        end
      end
      KIND_CLEAR: begin
        ctl.clear = accept;
        ok        = 1'b1;
        count_d   = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    tail_or = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      tail_or = tail_or | cell_tail[i];
    end
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    data_t left_data, right_data;
    logic  left_valid, right_valid;

    if (g == 0) begin : g_first
      assign left_data  = data_t'(req_i.push_value);
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = cell_data[g-1];
      assign left_valid = cell_valid[g-1];
    end

    if (g == NUM_CELLS - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = cell_data[g+1];
      assign right_valid = cell_valid[g+1];
    end

    cdq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .push_value_i  (data_t'(req_i.push_value)),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (cell_data[g]),
      .valid_o       (cell_valid[g]),
      .tail_data_o   (cell_tail[g])
    );
  end

  assign fill_ext = {{FILL_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_ok_q    <= ok;
      rsp_pop_q   <= popped;
      rsp_empty_q <= count_d == '0;
      rsp_full_q  <= count_d == CNT_W'(NUM_CELLS);
      rsp_fill_q  <= fill_ext[FILL_W-1:0];
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.ok         = rsp_ok_q;
  assign rsp_o.pop_value  = rsp_pop_q;
  assign rsp_o.is_empty   = rsp_empty_q;
  assign rsp_o.is_full    = rsp_full_q;
  assign rsp_o.fill_count = rsp_fill_q;

endmodule

// File: rtl/cdq_checker.sv
// Port-level assertions for the circular deque, bound to the top level.
module cdq_checker import cdq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic              rsp_ok_i,
  input logic [DATA_W-1:0] rsp_pop_value_i,
  input logic              rsp_is_empty_i,
  input logic              rsp_is_full_i,
  input logic [FILL_W-1:0] rsp_fill_count_i
);

  a_rsp_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> rsp_valid_i)
    else $error("no response after accepted request");

  a_empty_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(rsp_is_empty_i && rsp_is_full_i))
    else $error("empty and full both set");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_is_empty_i |-> rsp_fill_count_i == '0)
    else $error("empty with nonzero fill count");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ok_i |-> rsp_pop_value_i == '0)
    else $error("refused transaction returned data");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_pop_value_i) &&
      $stable(rsp_ok_i))
    else $error("stalled response changed");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_ok_i         (rsp_o.ok),
  .rsp_pop_value_i  (rsp_o.pop_value),
  .rsp_is_empty_i   (rsp_o.is_empty),
  .rsp_is_full_i    (rsp_o.is_full),
  .rsp_fill_count_i (rsp_o.fill_count)
);

// File: dv/circular_deque_unit_tb.sv
// Testbench for circular_deque_unit: directed and random deque requests checked against a ring predictor.
module circular_deque_unit_tb;
  import cdq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;
  localparam data_t VAL_MIN = 32'h8000_0000;
  localparam data_t VAL_MAX = 32'h7fff_ffff;

  typedef struct {
    logic              ok;
    data_t             pop_value;
    logic              is_empty;
    logic              is_full;
    logic [FILL_W-1:0] fill_count;
  } deque_rsp_t;

  typedef enum {RSP_ALWAYS, RSP_RANDOM, RSP_PERIODIC} rsp_mode_e;
  typedef enum {MIX_PUSH, MIX_POP, MIX_EVEN} op_mix_e;

  logic clk_i;
  logic rst_ni;

  cdq_req_if req_if ();
  cdq_rsp_if rsp_if ();

  circular_deque_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  data_t       ring_mem [DEPTH];
  int unsigned head_idx;
  int unsigned tail_idx;
  deque_rsp_t  expected_rsp_q [$];
  int unsigned err_count;
  rsp_mode_e   rsp_mode;
  bit          hold_req;
  int unsigned hold_len;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned ring_next(int unsigned idx);
    return (idx + 1 >= DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned ring_prev(int unsigned idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  // Apply one request to the deque state and return the status it produces.
  function automatic deque_rsp_t apply_request(logic [KIND_W-1:0] kind, data_t value);
    deque_rsp_t r;
    logic       was_empty;
    logic       was_full;
    was_empty   = (head_idx == tail_idx);
    was_full    = (ring_next(tail_idx) == head_idx);
    r.ok        = 1'b0;
    r.pop_value = '0;
    case (kind)
      KIND_PUSH_FRONT: if (!was_full) begin
        head_idx = ring_prev(head_idx);
        ring_mem[head_idx] = value;
        r.ok = 1'b1;
      end
      KIND_PUSH_BACK: if (!was_full) begin
        ring_mem[tail_idx] = value;
        tail_idx = ring_next(tail_idx);
        r.ok = 1'b1;
      end
      KIND_POP_FRONT: if (!was_empty) begin
        r.pop_value = ring_mem[head_idx];
        head_idx = ring_next(head_idx);
        r.ok = 1'b1;
      end
      KIND_POP_BACK: if (!was_empty) begin
        tail_idx = ring_prev(tail_idx);
        r.pop_value = ring_mem[tail_idx];
        r.ok = 1'b1;
      end
      KIND_CLEAR: begin
        head_idx = 0;
        tail_idx = 0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.is_empty   = (head_idx == tail_idx);
    r.is_full    = (ring_next(tail_idx) == head_idx);
    r.fill_count = FILL_W'((tail_idx + DEPTH - head_idx) % DEPTH);
    return r;
  endfunction

  task automatic send_req(logic [KIND_W-1:0] kind, data_t value);
    req_if.valid      <= 1'b1;
    req_if.kind       <= kind;
    req_if.push_value <= value;
    do @(posedge clk_i); while (!req_if.ready);
    expected_rsp_q.push_back(apply_request(kind, value));
  endtask

  task automatic idle_req(int unsigned cycles);
    req_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_rsp();
    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic data_t rand_value();
    case ($urandom_range(19))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] rand_kind(op_mix_e mix);
    int unsigned roll;
    int unsigned push_pct;
    roll = $urandom_range(99);
    if (roll < 1) return KIND_W'($urandom_range(KIND_RSVD_HI, KIND_RSVD_LO));
    if (roll < 3) return KIND_CLEAR;
    push_pct = (mix == MIX_PUSH) ? 75 : (mix == MIX_POP) ? 25 : 50;
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    return $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    deque_rsp_t exp_rsp;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        err_count++;
        $error("response transaction with no request outstanding");
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        check_field("ok", exp_rsp.ok, rsp_if.ok);
        check_field("pop_value", exp_rsp.pop_value, rsp_if.pop_value);
        check_field("is_empty", exp_rsp.is_empty, rsp_if.is_empty);
        check_field("is_full", exp_rsp.is_full, rsp_if.is_full);
        check_field("fill_count", exp_rsp.fill_count, rsp_if.fill_count);
      end
    end
  end

  // Response side: long hold on request, else the current stall pattern.
  initial begin
    int unsigned rsp_phase;
    rsp_phase = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      rsp_phase++;
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
      end else begin
        case (rsp_mode)
          RSP_ALWAYS: rsp_if.ready <= 1'b1;
          RSP_RANDOM: rsp_if.ready <= ($urandom_range(99) >= 30);
          default:    rsp_if.ready <= ((rsp_phase % 9) < 6);
        endcase
      end
    end
  end

  task automatic test_empty_and_unused();
    send_req(KIND_POP_FRONT, rand_value());
    send_req(KIND_POP_BACK, rand_value());
    for (int k = KIND_RSVD_LO; k <= KIND_RSVD_HI; k++) send_req(KIND_W'(k), rand_value());
  endtask

  task automatic test_value_extremes();
    send_req(KIND_PUSH_FRONT, VAL_MAX);
    send_req(KIND_PUSH_BACK, VAL_MIN);
    send_req(KIND_POP_BACK, '0);
    send_req(KIND_POP_FRONT, '1);
  endtask

  task automatic test_fill_and_refuse();
    for (int i = 0; i < DEPTH - 1; i++)
      send_req((i % 2) ? KIND_PUSH_BACK : KIND_PUSH_FRONT, $urandom);
    send_req(KIND_PUSH_FRONT, rand_value());
    send_req(KIND_PUSH_BACK, rand_value());
    send_req(KIND_CLEAR, rand_value());
  endtask

  task automatic test_backpressure();
    drain_rsp();
    rsp_mode = RSP_ALWAYS;
    hold_len = 150;
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_req(rand_kind(MIX_PUSH), rand_value());
    drain_rsp();
  endtask

  task automatic test_random(int unsigned target);
    int unsigned counted;
    int unsigned burst_left;
    int unsigned seg_left;
    bit          gaps_on;
    op_mix_e     mix;
    logic [KIND_W-1:0] kind;
    counted    = 0;
    burst_left = 0;
    seg_left   = 0;
    gaps_on    = 1'b1;
    mix        = MIX_EVEN;
    while (counted < target) begin
      if (counted % 200 == 0) begin
        rsp_mode = rsp_mode_e'($urandom_range(2));
        gaps_on  = ($urandom_range(3) != 0);
      end
      if (seg_left == 0) begin
        mix      = op_mix_e'($urandom_range(2));
        seg_left = $urandom_range(40, 5);
      end
      if (burst_left == 0) begin
        if (gaps_on) idle_req($urandom_range(6, 1));
        burst_left = $urandom_range(20, 1);
      end
      kind = rand_kind(mix);
      send_req(kind, rand_value());
      burst_left--;
      seg_left--;
      if (kind <= KIND_CLEAR) counted++;
      if (counted % 350 == 349) drain_rsp();
    end
  endtask

  initial begin
    head_idx  = 0;
    tail_idx  = 0;
    err_count = 0;
    hold_req  = 1'b0;
    hold_len  = 0;
    rsp_mode  = RSP_RANDOM;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.kind       <= KIND_CLEAR;
    req_if.push_value <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_unused();
    test_value_extremes();
    test_fill_and_refuse();
    test_backpressure();
    test_random(1400);

    drain_rsp();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: circular_deque_unit.f
rtl/cdq_pkg.sv
rtl/cdq_if.sv
rtl/cdq_cell.sv
rtl/circular_deque_unit.sv
rtl/cdq_checker.sv
dv/circular_deque_unit_tb.sv
